/* design/ssq_pkg.sv */
// Shared types, codes and defaults of the step sequencer pattern engine.
`timescale 1ns / 1ps
`default_nettype none

package ssq_pkg;

	// Default sizes of the pattern store.
	localparam int DEF_PATTERN_SLOTS = 8;
	localparam int DEF_STEP_SLOTS    = 8;
	localparam int DEF_VALUE_BITS    = 12;

	// Fixed widths of the configuration port.
	localparam int CFG_DATA_W  = 4;
	localparam int CFG_INDEX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_REPEAT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DAC_HEADER = 2'd2;

	// Configuration reset values.
	localparam logic       DIRECTION_RESET  = 1'b0;
	localparam logic [1:0] MAX_REPEAT_RESET = 2'd2;
	localparam logic [3:0] DAC_HEADER_RESET = 4'd5;

	// Command opcodes.
	localparam logic [2:0] OP_CLOCK   = 3'd0;
	localparam logic [2:0] OP_BUTTON  = 3'd1;
	localparam logic [2:0] OP_SAMPLE  = 3'd2;
	localparam logic [2:0] OP_ENCODER = 3'd3;
	localparam logic [2:0] OP_RECORD  = 3'd4;

	// Saturation bound of a pattern length.
	localparam logic [4:0] LEN_MAX = 5'd31;

	// Configuration registers as seen by the sequencer.
	typedef struct packed {
		logic       direction;
		logic [1:0] max_repeat;
		logic [3:0] dac_header;
	} cfg_t;

	// Port strobes of the step store.
	typedef struct packed {
		logic wr;
		logic rd;
	} mem_cmd_t;

endpackage

`default_nettype wire

/* design/ssq_store.sv */
// Step store: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module ssq_store #(
	parameter int DEPTH  = ssq_pkg::DEF_PATTERN_SLOTS * ssq_pkg::DEF_STEP_SLOTS,
	parameter int DATA_W = ssq_pkg::DEF_VALUE_BITS + 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ssq_pkg::mem_cmd_t        cmd,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);

	// An entry never written reads as enabled with all other fields zero.
	localparam logic [DATA_W-1:0] RESET_WORD = {1'b1, {(DATA_W-1){1'b0}}};

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [DATA_W-1:0] rd_word_q;
	logic              rd_valid_q;

	// Storage array with registered read data.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd) begin
			rd_word_q <= mem[raddr];
		end
	end

	// Valid bits are cleared by reset and set on the first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.wr) begin
				valid_q[waddr] <= 1'b1;
			end
			if (cmd.rd) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_word_q : RESET_WORD;

endmodule

`default_nettype wire

/* design/ssq_ctrl.sv */
// Sequencer: decodes commands, runs read-modify-write passes and the step scan.
`timescale 1ns / 1ps
`default_nettype none

module ssq_ctrl #(
	parameter int NUM_PATTERN_SLOTS = ssq_pkg::DEF_PATTERN_SLOTS,
	parameter int NUM_STEP_SLOTS    = ssq_pkg::DEF_STEP_SLOTS,
	parameter int VALUE_BITS        = ssq_pkg::DEF_VALUE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          opcode,
	input  logic [7:0]          button_map,
	input  logic [11:0]         sample_value,
	input  logic [1:0]          encoder_phase,
	input  ssq_pkg::cfg_t       cfg,
	output ssq_pkg::mem_cmd_t   mem_cmd,
	output logic [$clog2(NUM_PATTERN_SLOTS*NUM_STEP_SLOTS)-1:0] mem_waddr,
	output logic [$clog2(NUM_PATTERN_SLOTS*NUM_STEP_SLOTS)-1:0] mem_raddr,
	output logic [VALUE_BITS+4:0] mem_wdata,
	input  logic [VALUE_BITS+4:0] mem_rdata,
	output logic                done,
	output logic [2:0]          step_index,
	output logic [2:0]          pattern_index,
	output logic [15:0]         dac_word,
	output logic                record_enable,
	output logic [4:0]          sequence_length,
	output logic                no_enabled_step
);

	localparam int STEP_W = $clog2(NUM_STEP_SLOTS);
	localparam int PAT_W  = $clog2(NUM_PATTERN_SLOTS);
	localparam int ADDR_W = $clog2(NUM_PATTERN_SLOTS * NUM_STEP_SLOTS);
	localparam int CNT_W  = $clog2(NUM_STEP_SLOTS + 1);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEP_SLOTS - 1);
	localparam logic [PAT_W-1:0]  LAST_PAT  = PAT_W'(NUM_PATTERN_SLOTS - 1);
	localparam logic [CNT_W-1:0]  SCAN_ALL  = CNT_W'(NUM_STEP_SLOTS);
	localparam logic [4:0]        LEN_RESET =
		(NUM_STEP_SLOTS > 31) ? ssq_pkg::LEN_MAX : 5'(NUM_STEP_SLOTS);

	// Encoder phase codes.
	localparam logic [1:0] PHASE_A    = 2'd1;
	localparam logic [1:0] PHASE_B    = 2'd2;
	localparam logic [1:0] PHASE_BOTH = 2'd3;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MOD  = 5'b00010,
		ST_SCAN = 5'b00100,
		ST_FIN  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	logic [2:0]            op_q;
	logic [STEP_W-1:0]     tgt_q;
	logic [VALUE_BITS-1:0] sample_q;
	logic [STEP_W-1:0]     cand_q;
	logic [CNT_W-1:0]      scan_cnt_q;
	logic                  held_q;
	logic [STEP_W-1:0]     cur_step_q;
	logic [PAT_W-1:0]      pat_q;
	logic                  rec_q;
	logic [1:0]            prev_phase_q;
	logic [4:0]            len_q [NUM_PATTERN_SLOTS];

	logic                  done_q;
	logic [2:0]            step_index_q;
	logic [2:0]            pattern_index_q;
	logic [15:0]           dac_word_q;
	logic                  record_enable_q;
	logic [4:0]            sequence_length_q;
	logic                  no_enabled_step_q;

	// Store address of a step in a pattern.
	function automatic logic [ADDR_W-1:0] slot_addr(
		input logic [PAT_W-1:0]  p,
		input logic [STEP_W-1:0] s
	);
		return ADDR_W'(int'(p) * NUM_STEP_SLOTS + int'(s));
	endfunction

	// Neighbor step in play order, with wrap.
	function automatic logic [STEP_W-1:0] step_after(
		input logic [STEP_W-1:0] s,
		input logic              backward
	);
		logic [STEP_W-1:0] r;
		if (!backward) begin
			r = (s == LAST_STEP) ? '0 : s + STEP_W'(1);
		end else begin
			r = (s == '0) ? LAST_STEP : s - STEP_W'(1);
		end
		return r;
	endfunction

	logic accept;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Button decode: one-hot check and bit position.
	logic       map_onehot;
	logic [2:0] press_bit;
	logic       press_ok;
	always_comb begin
		press_bit = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (button_map[i]) begin
				press_bit = press_bit | 3'(i);
			end
		end
	end
	assign map_onehot = (button_map != 8'd0) &&
		((button_map & (button_map - 8'd1)) == 8'd0);
	assign press_ok = map_onehot && (int'(press_bit) < NUM_STEP_SLOTS);

	// Which commands touch the store, and at which step.
	logic              need_rmw;
	logic [STEP_W-1:0] tgt_step;
	assign need_rmw = (opcode == ssq_pkg::OP_CLOCK) ||
		((opcode == ssq_pkg::OP_BUTTON) && press_ok) ||
		((opcode == ssq_pkg::OP_SAMPLE) && rec_q);
	assign tgt_step = (opcode == ssq_pkg::OP_BUTTON) ? STEP_W'(press_bit) : cur_step_q;

	// Fields of the entry on the read port.
	logic                  e_en;
	logic [VALUE_BITS-1:0] e_val;
	logic [1:0]            e_rep;
	logic [1:0]            e_cnt;
	logic                  cnt_zero;
	assign e_en     = mem_rdata[VALUE_BITS+4];
	assign e_val    = mem_rdata[4 +: VALUE_BITS];
	assign e_rep    = mem_rdata[3:2];
	assign e_cnt    = mem_rdata[1:0];
	assign cnt_zero = (e_cnt == 2'd0);

	logic [4:0] len_cur;
	assign len_cur = len_q[pat_q];

	// Entry and length update for the pass in ST_MOD.
	logic                  w_en;
	logic [VALUE_BITS-1:0] w_val;
	logic [1:0]            w_rep;
	logic [1:0]            w_cnt;
	logic [4:0]            len_nxt;
	logic [2:0]            drop;
	always_comb begin
		w_en    = e_en;
		w_val   = e_val;
		w_rep   = e_rep;
		w_cnt   = e_cnt;
		len_nxt = len_cur;
		drop    = {1'b0, e_rep} + 3'd1;
		case (op_q)
			ssq_pkg::OP_CLOCK: begin
				w_cnt = cnt_zero ? e_rep : e_cnt - 2'd1;
			end
			ssq_pkg::OP_BUTTON: begin
				if (e_en) begin
					if (e_rep < cfg.max_repeat) begin
						w_rep = e_rep + 2'd1;
						if (e_cnt != 2'd3) begin
							w_cnt = e_cnt + 2'd1;
						end
						if (len_cur != ssq_pkg::LEN_MAX) begin
							len_nxt = len_cur + 5'd1;
						end
					end else begin
						len_nxt = (len_cur > 5'(drop)) ? len_cur - 5'(drop) : 5'd0;
						w_en    = 1'b0;
						w_rep   = 2'd0;
						w_cnt   = 2'd0;
					end
				end else begin
					w_en = 1'b1;
					if (len_cur != ssq_pkg::LEN_MAX) begin
						len_nxt = len_cur + 5'd1;
					end
				end
			end
			ssq_pkg::OP_SAMPLE: begin
				w_val = sample_q;
			end
			default: begin
			end
		endcase
	end

	// Store port control: reads and writes never hit one entry in one cycle.
	always_comb begin
		mem_cmd   = '0;
		mem_raddr = slot_addr(pat_q, cur_step_q);
		mem_waddr = slot_addr(pat_q, tgt_q);
		mem_wdata = {w_en, w_val, w_rep, w_cnt};
		unique case (state_q)
			ST_IDLE: begin
				if (accept && need_rmw) begin
					mem_cmd.rd = 1'b1;
					mem_raddr  = slot_addr(pat_q, tgt_step);
				end
			end
			ST_MOD: begin
				mem_cmd.wr = 1'b1;
				if ((op_q == ssq_pkg::OP_CLOCK) && cnt_zero) begin
					mem_cmd.rd = 1'b1;
					mem_raddr  = slot_addr(pat_q, step_after(cur_step_q, cfg.direction));
				end
			end
			ST_SCAN: begin
				if (!e_en && (scan_cnt_q != SCAN_ALL)) begin
					mem_cmd.rd = 1'b1;
					mem_raddr  = slot_addr(pat_q, step_after(cand_q, cfg.direction));
				end
			end
			ST_FIN: begin
				mem_cmd.rd = 1'b1;
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = need_rmw ? ST_MOD : ST_FIN;
				end
			end
			ST_MOD: begin
				state_d = ((op_q == ssq_pkg::OP_CLOCK) && cnt_zero) ? ST_SCAN : ST_FIN;
			end
			ST_SCAN: begin
				if (e_en || (scan_cnt_q == SCAN_ALL)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state: sequencer position, pattern, recording and lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= ssq_pkg::OP_CLOCK;
			scan_cnt_q   <= '0;
			held_q       <= 1'b0;
			cur_step_q   <= '0;
			pat_q        <= '0;
			rec_q        <= 1'b0;
			prev_phase_q <= 2'd0;
			done_q       <= 1'b0;
			for (int p = 0; p < NUM_PATTERN_SLOTS; p++) begin
				len_q[p] <= LEN_RESET;
			end
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_OUT);
			if (accept) begin
				op_q   <= opcode;
				held_q <= 1'b0;
				if (opcode == ssq_pkg::OP_ENCODER) begin
					rec_q        <= 1'b0;
					prev_phase_q <= encoder_phase;
					if ((prev_phase_q == PHASE_BOTH) && (encoder_phase == PHASE_B)) begin
						pat_q <= (pat_q == LAST_PAT) ? '0 : pat_q + PAT_W'(1);
					end else if ((prev_phase_q == PHASE_BOTH) &&
						(encoder_phase == PHASE_A)) begin
						pat_q <= (pat_q == '0) ? LAST_PAT : pat_q - PAT_W'(1);
					end
				end
				if (opcode == ssq_pkg::OP_RECORD) begin
					rec_q <= !rec_q;
				end
			end
			if (state_q == ST_MOD) begin
				if (op_q == ssq_pkg::OP_BUTTON) begin
					len_q[pat_q] <= len_nxt;
				end
				scan_cnt_q <= CNT_W'(1);
			end
			if (state_q == ST_SCAN) begin
				if (e_en) begin
					cur_step_q <= cand_q;
				end else if (scan_cnt_q == SCAN_ALL) begin
					held_q <= 1'b1;
				end else begin
					scan_cnt_q <= scan_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Payload registers: latched command fields, scan candidate, result beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q    <= tgt_step;
			sample_q <= sample_value[VALUE_BITS-1:0];
		end
		if (state_q == ST_MOD) begin
			cand_q <= step_after(cur_step_q, cfg.direction);
		end
		if ((state_q == ST_SCAN) && !e_en) begin
			cand_q <= step_after(cand_q, cfg.direction);
		end
		if (state_q == ST_OUT) begin
			step_index_q      <= 3'(cur_step_q);
			pattern_index_q   <= 3'(pat_q);
			dac_word_q        <= {cfg.dac_header, 12'd0} + 16'(e_val);
			record_enable_q   <= rec_q;
			sequence_length_q <= len_cur;
			no_enabled_step_q <= held_q;
		end
	end

	assign done            = done_q;
	assign step_index      = step_index_q;
	assign pattern_index   = pattern_index_q;
	assign dac_word        = dac_word_q;
	assign record_enable   = record_enable_q;
	assign sequence_length = sequence_length_q;
	assign no_enabled_step = no_enabled_step_q;

endmodule

`default_nettype wire

/* design/step_sequencer_pattern_engine_core.sv */
// Top level of the step sequencer pattern engine: configuration, store, sequencer.
//
//   Channel   Direction  Handshake          Beat contents
//   command   in         start && !busy     opcode, button_map, sample_value, encoder_phase
//   result    out        done (one cycle)   step_index, pattern_index, dac_word,
//                                           record_enable, sequence_length, no_enabled_step
//   config    in         cfg_we             cfg_index, cfg_data
//
// States from one accepted command to the next: encoder, record toggle, unused
// opcodes, rejected button maps and samples while not recording go through ST_FIN
// and ST_OUT; accepted button presses and recorded samples add an ST_MOD pass; a
// clock edge adds ST_MOD and, when the current step no longer counts down a repeat,
// an ST_SCAN over 1 to NUM_STEP_SLOTS steps, one store read per cycle on one port.
// The result beat is shown in the cycle in which busy drops, and a new
// command may be accepted in that same cycle. The receiver cannot stall.
// Reset clears per-entry valid bits, so the store reads as all steps enabled
// with zero value and repeat at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module step_sequencer_pattern_engine_core #(
	parameter int NUM_PATTERN_SLOTS = ssq_pkg::DEF_PATTERN_SLOTS,
	parameter int NUM_STEP_SLOTS    = ssq_pkg::DEF_STEP_SLOTS,
	parameter int VALUE_BITS        = ssq_pkg::DEF_VALUE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         opcode,
	input  logic [7:0]                         button_map,
	input  logic [11:0]                        sample_value,
	input  logic [1:0]                         encoder_phase,
	output logic                               done,
	output logic [2:0]                         step_index,
	output logic [2:0]                         pattern_index,
	output logic [15:0]                        dac_word,
	output logic                               record_enable,
	output logic [4:0]                         sequence_length,
	output logic                               no_enabled_step,
	input  logic                               cfg_we,
	input  logic [ssq_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ssq_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int STORE_DEPTH = NUM_PATTERN_SLOTS * NUM_STEP_SLOTS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DATA_W      = VALUE_BITS + 5;

	ssq_pkg::cfg_t     cfg_q;
	ssq_pkg::mem_cmd_t mem_cmd;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction  <= ssq_pkg::DIRECTION_RESET;
			cfg_q.max_repeat <= ssq_pkg::MAX_REPEAT_RESET;
			cfg_q.dac_header <= ssq_pkg::DAC_HEADER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssq_pkg::REG_DIRECTION:  cfg_q.direction  <= cfg_data[0];
				ssq_pkg::REG_MAX_REPEAT: cfg_q.max_repeat <= cfg_data[1:0];
				ssq_pkg::REG_DAC_HEADER: cfg_q.dac_header <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Step store.
	ssq_store #(
		.DEPTH  (STORE_DEPTH),
		.DATA_W (DATA_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mem_cmd),
		.waddr  (mem_waddr),
		.raddr  (mem_raddr),
		.wdata  (mem_wdata),
		.rdata  (mem_rdata)
	);

	// Command sequencer.
	ssq_ctrl #(
		.NUM_PATTERN_SLOTS (NUM_PATTERN_SLOTS),
		.NUM_STEP_SLOTS    (NUM_STEP_SLOTS),
		.VALUE_BITS        (VALUE_BITS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.button_map      (button_map),
		.sample_value    (sample_value),
		.encoder_phase   (encoder_phase),
		.cfg             (cfg_q),
		.mem_cmd         (mem_cmd),
		.mem_waddr       (mem_waddr),
		.mem_raddr       (mem_raddr),
		.mem_wdata       (mem_wdata),
		.mem_rdata       (mem_rdata),
		.done            (done),
		.step_index      (step_index),
		.pattern_index   (pattern_index),
		.dac_word        (dac_word),
		.record_enable   (record_enable),
		.sequence_length (sequence_length),
		.no_enabled_step (no_enabled_step)
	);

endmodule

`default_nettype wire

/* design/ssq_chk.sv */
// Port-level checker of the step sequencer pattern engine and its bind.
`timescale 1ns / 1ps
`default_nettype none

module ssq_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted command always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	// Busy only rises after a command was offered.
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// Every drop of busy comes with its result beat.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result beat");

	// A result beat is a single-cycle strobe shown while idle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy ##1 !done))
		else $error("result beat not a single idle cycle");

endmodule

bind step_sequencer_pattern_engine_core ssq_chk u_ssq_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
